### rtl/core/srwl_pkg.sv
// Shared types, codes and constants of the slot reader/writer lock table.
package srwl_pkg;

  localparam int SLOT_COUNT  = 16;
  localparam int SLOT_W      = 4;
  localparam int MAX_READERS = 255;
  localparam int READER_CAP  = (MAX_READERS < 255) ? MAX_READERS : 255;

  localparam logic [2:0] ACT_WR_ACQUIRE = 3'd0;
  localparam logic [2:0] ACT_POLL_DRAIN = 3'd1;
  localparam logic [2:0] ACT_ABANDON    = 3'd2;
  localparam logic [2:0] ACT_COMMIT     = 3'd3;
  localparam logic [2:0] ACT_WR_RELEASE = 3'd4;
  localparam logic [2:0] ACT_RD_ACQUIRE = 3'd5;
  localparam logic [2:0] ACT_VALIDATE   = 3'd6;
  localparam logic [2:0] ACT_RD_RELEASE = 3'd7;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_READY  = 3'd1;
  localparam logic [2:0] ST_HELD       = 3'd2;
  localparam logic [2:0] ST_DRAIN_WAIT = 3'd3;
  localparam logic [2:0] ST_BAD_GEN    = 3'd4;
  localparam logic [2:0] ST_COUNT_ERR  = 3'd5;

  localparam logic [1:0] PH_FREE      = 2'd0;
  localparam logic [1:0] PH_WRITING   = 2'd1;
  localparam logic [1:0] PH_COMMITTED = 2'd2;
  localparam logic [1:0] PH_DRAINING  = 2'd3;

  typedef struct packed {
    logic [2:0]        action;
    logic [SLOT_W-1:0] slot_index;
    logic [31:0]       requester_id;
    logic              owner_alive;
    logic [63:0]       captured_generation;
    logic [63:0]       commit_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] owner;
    logic [7:0]  readers;
    logic [63:0] gen;
    logic        drained;
  } slot_entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] generation_out;
    logic        reclaimed;
    logic [7:0]  readers_now;
    logic [1:0]  slot_state_out;
    logic [63:0] last_commit_out;
  } result_t;

endpackage

### rtl/core/srwl_exec.sv
// Combinational update of one slot entry and the result word for one request.
module srwl_exec (
  input  srwl_pkg::req_t        req,
  input  srwl_pkg::slot_entry_t entry,
  input  logic [63:0]           last_commit,
  output srwl_pkg::slot_entry_t entry_next,
  output logic [63:0]           last_commit_next,
  output logic                  in_range,
  output srwl_pkg::result_t     result
);
  import srwl_pkg::*;

  logic [2:0] status;
  logic       reclaimed;
  logic       is_write;

  assign in_range = ({1'b0, req.slot_index} < (SLOT_W + 1)'(SLOT_COUNT));

  always_comb begin
    entry_next       = entry;
    last_commit_next = last_commit;
    status           = ST_OK;
    reclaimed        = 1'b0;
    is_write         = req.action inside {ACT_WR_ACQUIRE, ACT_POLL_DRAIN, ACT_ABANDON,
                                          ACT_COMMIT, ACT_WR_RELEASE};
    if (!in_range) begin
      status = ST_NOT_READY;
    end else if (is_write && req.requester_id == '0) begin
      status = ST_NOT_READY;
    end else if (req.action == ACT_WR_ACQUIRE) begin
      if (entry.owner != '0 && req.owner_alive) begin
        status = ST_HELD;
      end else begin
        reclaimed        = (entry.owner != '0);
        entry_next.owner = req.requester_id;
        if (entry.phase == PH_COMMITTED) begin
          entry_next.phase   = PH_DRAINING;
          entry_next.drained = 1'b1;
        end else begin
          entry_next.drained = 1'b0;
        end
        if (entry.readers == '0) begin
          entry_next.phase   = PH_WRITING;
          entry_next.drained = 1'b0;
        end else begin
          status = ST_DRAIN_WAIT;
        end
      end
    end else if (is_write && entry.owner != req.requester_id) begin
      status = ST_HELD;
    end else begin
      case (req.action)
        ACT_POLL_DRAIN: begin
          if (entry.readers == '0) begin
            entry_next.phase   = PH_WRITING;
            entry_next.drained = 1'b0;
          end else begin
            status = ST_DRAIN_WAIT;
          end
        end
        ACT_ABANDON: begin
          if (entry.drained) begin
            entry_next.phase = PH_COMMITTED;
          end
          entry_next.drained = 1'b0;
          entry_next.owner   = '0;
        end
        ACT_COMMIT: begin
          if (entry.phase != PH_WRITING) begin
            status = ST_NOT_READY;
          end else begin
            entry_next.gen     = entry.gen + 64'd1;
            entry_next.phase   = PH_COMMITTED;
            entry_next.owner   = '0;
            entry_next.drained = 1'b0;
            last_commit_next   = req.commit_id;
          end
        end
        ACT_WR_RELEASE: begin
          entry_next.phase   = PH_FREE;
          entry_next.owner   = '0;
          entry_next.drained = 1'b0;
        end
        ACT_RD_ACQUIRE: begin
          if (entry.phase != PH_COMMITTED) begin
            status = ST_NOT_READY;
          end else if (entry.readers >= 8'(READER_CAP)) begin
            status = ST_COUNT_ERR;
          end else begin
            entry_next.readers = entry.readers + 8'd1;
          end
        end
        ACT_VALIDATE: begin
          status = (entry.gen == req.captured_generation) ? ST_OK : ST_BAD_GEN;
        end
        ACT_RD_RELEASE: begin
          if (entry.readers == '0) begin
            status = ST_COUNT_ERR;
          end else begin
            entry_next.readers = entry.readers - 8'd1;
          end
        end
        default: begin
          status = ST_NOT_READY;
        end
      endcase
    end
  end

  // Out-of-range slots report zeros for the per-slot fields.
  always_comb begin
    result.status          = status;
    result.reclaimed       = reclaimed;
    result.last_commit_out = last_commit_next;
    result.generation_out  = in_range ? entry_next.gen     : '0;
    result.readers_now     = in_range ? entry_next.readers : '0;
    result.slot_state_out  = in_range ? entry_next.phase   : PH_FREE;
  end

endmodule

### rtl/core/slot_reader_writer_lock.sv
// Slot reader/writer lock table: top level with request register, slot table and result register.
// An accepted word passes the request register, then the result register that drives the outputs.
// Throughput: one request word per cycle unless a stalled result word holds it; the slot table is
//   updated with the result capture, so back-to-back requests to one slot see each other's updates.
// Reset (rst, synchronous, active high): all slots free, unlocked, zero readers, generation
//   zero; last commit identifier zero; both pipeline stages empty. No clearing pass needed.
module slot_reader_writer_lock (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [3:0]  slot_index,
  input  logic [31:0] requester_id,
  input  logic        owner_alive,
  input  logic [63:0] captured_generation,
  input  logic [63:0] commit_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [63:0] generation_out,
  output logic        reclaimed,
  output logic [7:0]  readers_now,
  output logic [1:0]  slot_state_out,
  output logic [63:0] last_commit_out
);
  import srwl_pkg::*;

  // Slot table, one register set per slot.
  slot_entry_t slots [SLOT_COUNT];
  logic [63:0] last_commit;

  // Request stage.
  req_t    req_q;
  logic    req_valid;

  // Result stage.
  result_t res_q;

  slot_entry_t entry_cur;
  slot_entry_t entry_next;
  logic [63:0] last_commit_next;
  logic        in_range;
  result_t     result;
  logic        advance;
  logic        accept;

  // The request stage moves on whenever the result register is empty or being drained.
  assign advance  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Entry read; an out-of-range index never writes and its fields are masked in the exec.
  assign entry_cur = in_range ? slots[req_q.slot_index] : '0;

  srwl_exec u_exec (
    .req              (req_q),
    .entry            (entry_cur),
    .last_commit      (last_commit),
    .entry_next       (entry_next),
    .last_commit_next (last_commit_next),
    .in_range         (in_range),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (accept) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q.action              <= action;
      req_q.slot_index          <= slot_index;
      req_q.requester_id        <= requester_id;
      req_q.owner_alive         <= owner_alive;
      req_q.captured_generation <= captured_generation;
      req_q.commit_id           <= commit_id;
    end
  end

  // Table write-back happens together with the result capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots[i] <= '0;
      end
      last_commit <= '0;
    end else if (advance) begin
      if (in_range) begin
        slots[req_q.slot_index] <= entry_next;
      end
      last_commit <= last_commit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign status          = res_q.status;
  assign generation_out  = res_q.generation_out;
  assign reclaimed       = res_q.reclaimed;
  assign readers_now     = res_q.readers_now;
  assign slot_state_out  = res_q.slot_state_out;
  assign last_commit_out = res_q.last_commit_out;

`ifndef SYNTHESIS
  // A slot's reader count never goes past the cap.
  a_reader_cap: assert property (@(posedge clk) disable iff (rst)
    advance && in_range |-> entry_next.readers <= 8'(READER_CAP))
    else $error("reader count above cap");

  // A successful commit publishes its identifier.
  a_commit_publish: assert property (@(posedge clk) disable iff (rst)
    advance && req_q.action == ACT_COMMIT && result.status == ST_OK
    |=> last_commit == $past(req_q.commit_id))
    else $error("commit identifier not published");

  // A request leaving the request stage always lands in the result register.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result word lost");
`endif

endmodule

### verif/srwl_checker.sv
// Checker for the slot lock table: watches both channels, predicts each result word, compares.
module srwl_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  action,
  input  logic [3:0]  slot_index,
  input  logic [31:0] requester_id,
  input  logic        owner_alive,
  input  logic [63:0] captured_generation,
  input  logic [63:0] commit_id,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [63:0] generation_out,
  input  logic        reclaimed,
  input  logic [7:0]  readers_now,
  input  logic [1:0]  slot_state_out,
  input  logic [63:0] last_commit_out,
  output int          fail_count,
  output int          awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  import srwl_pkg::*;

  // shadow lock table
  logic [1:0]  phase_tbl   [SLOT_COUNT];
  logic [31:0] owner_tbl   [SLOT_COUNT];
  logic [7:0]  readers_tbl [SLOT_COUNT];
  logic [63:0] gen_tbl     [SLOT_COUNT];
  logic        from_commit [SLOT_COUNT];
  logic [63:0] commit_seen;

  result_t     pending_replies [$];
  int          fails;

  // zero readers finish the drain and hand the slot to the writer
  function automatic logic [2:0] settle_drain(int s);
    if (readers_tbl[s] == 8'd0) begin
      phase_tbl[s]   = PH_WRITING;
      from_commit[s] = 1'b0;
      return ST_OK;
    end
    return ST_DRAIN_WAIT;
  endfunction

  function automatic result_t lock_table_step(req_t w);
    result_t r;
    int      s;
    logic    writer_op;
    s         = int'(w.slot_index);
    writer_op = (w.action <= ACT_WR_RELEASE);
    r         = '0;
    r.status  = ST_OK;
    if (writer_op && w.requester_id == 32'd0) begin
      r.status = ST_NOT_READY;
    end else if (w.action == ACT_WR_ACQUIRE) begin
      if (owner_tbl[s] != 32'd0 && w.owner_alive) begin
        r.status = ST_HELD;
      end else begin
        r.reclaimed    = (owner_tbl[s] != 32'd0);
        owner_tbl[s]   = w.requester_id;
        from_commit[s] = (phase_tbl[s] == PH_COMMITTED);
        if (phase_tbl[s] == PH_COMMITTED) phase_tbl[s] = PH_DRAINING;
        r.status = settle_drain(s);
      end
    end else if (writer_op && owner_tbl[s] != w.requester_id) begin
      r.status = ST_HELD;
    end else begin
      case (w.action)
        ACT_POLL_DRAIN: r.status = settle_drain(s);
        ACT_ABANDON: begin
          if (from_commit[s]) phase_tbl[s] = PH_COMMITTED;
          from_commit[s] = 1'b0;
          owner_tbl[s]   = 32'd0;
        end
        ACT_COMMIT: begin
          if (phase_tbl[s] != PH_WRITING) begin
            r.status = ST_NOT_READY;
          end else begin
            gen_tbl[s]     = gen_tbl[s] + 64'd1;
            phase_tbl[s]   = PH_COMMITTED;
            commit_seen    = w.commit_id;
            owner_tbl[s]   = 32'd0;
            from_commit[s] = 1'b0;
          end
        end
        ACT_WR_RELEASE: begin
          phase_tbl[s]   = PH_FREE;
          owner_tbl[s]   = 32'd0;
          from_commit[s] = 1'b0;
        end
        ACT_RD_ACQUIRE: begin
          if (phase_tbl[s] != PH_COMMITTED) r.status = ST_NOT_READY;
          else if (readers_tbl[s] >= READER_CAP) r.status = ST_COUNT_ERR;
          else readers_tbl[s] = readers_tbl[s] + 8'd1;
        end
        ACT_VALIDATE: begin
          r.status = (gen_tbl[s] == w.captured_generation) ? ST_OK : ST_BAD_GEN;
        end
        default: begin
          if (readers_tbl[s] == 8'd0) r.status = ST_COUNT_ERR;
          else readers_tbl[s] = readers_tbl[s] - 8'd1;
        end
      endcase
    end
    r.generation_out  = gen_tbl[s];
    r.readers_now     = readers_tbl[s];
    r.slot_state_out  = phase_tbl[s];
    r.last_commit_out = commit_seen;
    return r;
  endfunction

  function automatic void check_field(string fname, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        phase_tbl[i]   = PH_FREE;
        owner_tbl[i]   = 32'd0;
        readers_tbl[i] = 8'd0;
        gen_tbl[i]     = 64'd0;
        from_commit[i] = 1'b0;
      end
      commit_seen = 64'd0;
      pending_replies.delete();
      fails = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {status, generation_out, reclaimed, readers_now, slot_state_out, last_commit_out};
        if (pending_replies.size() == 0) begin
          $error("result word arrived with no request outstanding");
          fails++;
        end else begin
          want = pending_replies.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("generation_out", want.generation_out, got.generation_out);
          check_field("reclaimed", 64'(want.reclaimed), 64'(got.reclaimed));
          check_field("readers_now", 64'(want.readers_now), 64'(got.readers_now));
          check_field("slot_state_out", 64'(want.slot_state_out), 64'(got.slot_state_out));
          check_field("last_commit_out", want.last_commit_out, got.last_commit_out);
        end
      end
      if (in_valid && !in_stall) begin
        pending_replies.push_back(lock_table_step({action, slot_index, requester_id,
                                                   owner_alive, captured_generation,
                                                   commit_id}));
      end
    end
    awaiting   = pending_replies.size();
    fail_count = fails;
  end

endmodule

### verif/tb_top.sv
// Testbench top: drives request words into the slot lock table and gives the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srwl_pkg::*;

  localparam int RANDOM_WORDS = 700;
  localparam int QUIET_TAIL   = 80;       // last words run with no idling on either side
  localparam int LONG_HOLD    = 48;       // receiver hold-off, long enough to back up the input
  localparam int TIMEOUT_NS   = 3_000_000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  action;
  logic [3:0]  slot_index;
  logic [31:0] requester_id;
  logic        owner_alive;
  logic [63:0] captured_generation;
  logic [63:0] commit_id;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [63:0] generation_out;
  logic        reclaimed;
  logic [7:0]  readers_now;
  logic [1:0]  slot_state_out;
  logic [63:0] last_commit_out;
  int          fail_count;
  int          awaiting;

  // quiet and hold_long are shared between the sender and the receiver; words_sent is the sender's
  bit          quiet     = 1'b0;
  bit          hold_long = 1'b0;
  int          words_sent = 0;

  slot_reader_writer_lock uut (.*);

  srwl_checker lock_chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Mostly a few hot slots so writers and readers collide; now and then any slot.
  function automatic logic [3:0] pick_slot();
    if ($urandom_range(0, 9) < 8) return 4'($urandom_range(0, 3));
    return 4'($urandom_range(0, 15));
  endfunction

  // Small id pool keeps owner matches likely; zero, all-ones and wide ids mixed in.
  function automatic logic [31:0] pick_requester();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 5) return $urandom;
    return 32'($urandom_range(1, 3));
  endfunction

  // Offer one request word; optional idle burst first. Returns once the word is taken.
  task automatic put_word(input logic [2:0] act, input logic [3:0] slot,
                          input logic [31:0] who, input logic alive,
                          input logic [63:0] cap, input logic [63:0] cid);
    int gap;
    gap = (!quiet && $urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    action              <= act;
    slot_index          <= slot;
    requester_id        <= who;
    owner_alive         <= alive;
    captured_generation <= cap;
    commit_id           <= cid;
    in_valid            <= 1'b1;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic put_op(input logic [2:0] act, input logic [3:0] slot,
                        input logic [31:0] who, input logic alive);
    put_word(act, slot, who, alive, rnd64(), rnd64());
  endtask

  // Sender pause: drop valid and wait until every predicted result word is back.
  task automatic wait_all_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  // Writer flow: acquire, up to two drain polls with readers sometimes leaving, then usually finish it off.
  task automatic writer_session(input logic [3:0] slot);
    logic [31:0] who;
    int          polls;
    int          ending;
    who = pick_requester();
    put_op(ACT_WR_ACQUIRE, slot, who, $urandom_range(0, 4) != 0);
    polls = $urandom_range(0, 2);
    repeat (polls) begin
      if ($urandom_range(0, 1) != 0)
        put_op(ACT_RD_RELEASE, slot, pick_requester(), 1'($urandom_range(0, 1)));
      put_op(ACT_POLL_DRAIN, slot, who, 1'b1);
    end
    ending = $urandom_range(0, 9);
    if (ending < 6) put_op(ACT_COMMIT, slot, who, 1'b1);
    else if (ending == 6) put_op(ACT_ABANDON, slot, who, 1'b1);
    else if (ending == 7) put_op(ACT_WR_RELEASE, slot, who, 1'b1);
    // otherwise the lock stays held and later writers hit it
  endtask

  // Reader flow: acquire, validate, usually release. Skipped releases leave readers
  // inside so later writers have something to drain.
  task automatic reader_session(input logic [3:0] slot);
    logic [63:0] guess;
    guess = ($urandom_range(0, 3) != 0) ? 64'($urandom_range(0, 60)) : rnd64();
    put_op(ACT_RD_ACQUIRE, slot, pick_requester(), 1'($urandom_range(0, 1)));
    put_word(ACT_VALIDATE, slot, pick_requester(), 1'($urandom_range(0, 1)), guess, rnd64());
    if ($urandom_range(0, 3) != 0)
      put_op(ACT_RD_RELEASE, slot, pick_requester(), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 9) == 0)
      put_op(ACT_RD_RELEASE, slot, pick_requester(), 1'($urandom_range(0, 1)));
  endtask

  // Push one slot's reader count into its cap and past it, then back off a little.
  task automatic fill_reader_count(input logic [3:0] slot);
    put_op(ACT_WR_ACQUIRE, slot, 32'd9, 1'b0);    // take it over whoever holds it
    put_op(ACT_WR_RELEASE, slot, 32'd9, 1'b1);    // back to free
    put_op(ACT_WR_ACQUIRE, slot, 32'd9, 1'b1);    // free -> writing if no readers are left
    put_op(ACT_COMMIT, slot, 32'd9, 1'b1);
    repeat (READER_CAP + 2) put_op(ACT_RD_ACQUIRE, slot, pick_requester(), 1'b1);
    repeat (20) put_op(ACT_RD_RELEASE, slot, pick_requester(), 1'b1);
  endtask

  // Receiver: random stall bursts, one long hold-off on request, none in the tail.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        hold_long = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus
  initial begin
    int  first;
    int  stop_at;
    int  pick;
    bit  held_once;
    bit  paused_once;
    bit  saturated;
    rst                 = 1'b1;
    in_valid            = 1'b0;
    action              = ACT_VALIDATE;
    slot_index          = 4'd0;
    requester_id        = 32'd0;
    owner_alive         = 1'b0;
    captured_generation = 64'd0;
    commit_id           = 64'd0;
    held_once           = 1'b0;
    paused_once         = 1'b0;
    saturated           = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed part ---
    put_op(ACT_RD_RELEASE, 4'd0, 32'd1, 1'b1);                   // release with no readers
    put_word(ACT_VALIDATE, 4'd0, 32'd1, 1'b0, 64'd0, '1);         // generation zero matches
    put_word(ACT_VALIDATE, 4'd0, 32'd1, 1'b1, '1, 64'd0);         // mismatch
    put_op(ACT_WR_ACQUIRE, 4'd1, 32'd0, 1'b0);                   // zero requester refused
    put_op(ACT_WR_ACQUIRE, 4'd1, 32'd1, 1'b1);                   // free -> writing
    put_op(ACT_WR_ACQUIRE, 4'd1, 32'd1, 1'b1);                   // live owner, even itself: held
    put_op(ACT_WR_ACQUIRE, 4'd1, 32'd2, 1'b0);                   // dead owner: reclaim
    put_op(ACT_POLL_DRAIN, 4'd1, 32'd1, 1'b1);                   // old owner now locked out
    put_word(ACT_COMMIT, 4'd1, 32'd2, 1'b1, 64'd0, '1);           // generation 1, lock dropped
    put_op(ACT_COMMIT, 4'd1, 32'd2, 1'b1);                       // no longer owner: held
    put_op(ACT_RD_ACQUIRE, 4'd2, 32'd5, 1'b1);                   // free slot: not ready
    put_op(ACT_RD_ACQUIRE, 4'd1, 32'd5, 1'b0);
    put_op(ACT_RD_ACQUIRE, 4'd1, 32'd6, 1'b1);                   // two readers inside
    put_op(ACT_WR_ACQUIRE, 4'd1, 32'hFFFF_FFFF, 1'b1);           // committed -> draining
    put_op(ACT_RD_ACQUIRE, 4'd1, 32'd7, 1'b1);                   // no new readers while draining
    put_op(ACT_COMMIT, 4'd1, 32'hFFFF_FFFF, 1'b1);               // not writing yet: not ready
    put_op(ACT_POLL_DRAIN, 4'd1, 32'hFFFF_FFFF, 1'b1);           // still draining
    put_op(ACT_ABANDON, 4'd1, 32'hFFFF_FFFF, 1'b1);              // restores committed
    put_op(ACT_WR_ACQUIRE, 4'd1, 32'd3, 1'b1);
    put_op(ACT_RD_RELEASE, 4'd1, 32'd5, 1'b1);
    put_op(ACT_RD_RELEASE, 4'd1, 32'd6, 1'b0);
    put_op(ACT_POLL_DRAIN, 4'd1, 32'd3, 1'b1);                   // drained -> writing
    put_op(ACT_POLL_DRAIN, 4'd1, 32'd0, 1'b1);                   // zero requester on poll
    put_op(ACT_WR_RELEASE, 4'd1, 32'd3, 1'b1);                   // back to free
    put_word(ACT_VALIDATE, 4'd1, 32'd3, 1'b1, 64'd1, 64'd0);      // generation 1 matches
    put_op(ACT_WR_ACQUIRE, 4'd15, 32'd9, 1'b1);
    put_op(ACT_ABANDON, 4'd15, 32'd9, 1'b1);                     // abandon not from commit
    wait_all_results();

    // --- random part ---
    first   = words_sent;
    stop_at = first + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      quiet = (words_sent >= stop_at - QUIET_TAIL);
      if (!saturated && words_sent >= first + 100) begin
        saturated = 1'b1;
        fill_reader_count(4'd14);
      end
      if (!held_once && words_sent >= first + 420) begin
        held_once = 1'b1;
        hold_long = 1'b1;          // sender keeps going, the block backs up
      end
      if (!paused_once && words_sent >= first + 520) begin
        paused_once = 1'b1;
        wait_all_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) writer_session(pick_slot());
      else if (pick < 85) reader_session(pick_slot());
      else put_word(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                    ($urandom_range(0, 1) != 0) ? $urandom : pick_requester(),
                    1'($urandom_range(0, 1)), rnd64(), rnd64());
    end

    // --- wind down ---
    wait_all_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
